// ----- rtl/core/fir_pkg.sv -----
// ----------------------------------------------------------------------------
// fir_pkg: shared definitions of the FIR filter
// Widths, reset values, request codes and the control bundle that the
// sequencer hands to the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int unsigned MAX_TAPS_DEF    = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned COEF_BITS  = 16;
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned TAP_CNT_W  = 7;
  localparam int unsigned COEF_IDX_W = 6;
  localparam int unsigned CMD_W      = 2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 7'd64;

  localparam logic [0:0] REG_TAP_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
    logic rnd;
    logic load;
  } mac_ctrl_t;

endpackage

// ----- rtl/core/fir_ram.sv -----
// ----------------------------------------------------------------------------
// fir_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/fir_mac.sv -----
// ----------------------------------------------------------------------------
// fir_mac: shared multiply-accumulate datapath
// One multiplier and one accumulator walk the taps; the sum is then
// rounded, shifted and saturated into the output register.
// ----------------------------------------------------------------------------
module fir_mac #(
  parameter int unsigned MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  fir_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [fir_pkg::COEF_BITS-1:0]  coef_i,
  input  logic signed [SAMPLE_BITS-1:0]         hist_i,
  output logic signed [SAMPLE_BITS-1:0]         filtered_o,
  output logic                                  saturated_o
);
  import fir_pkg::*;

  localparam int unsigned PW    = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_W = PW + $clog2(MAX_TAPS);
  localparam int unsigned RW    = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PW-1:0]          prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [ACC_W-1:0]       rsum;
  logic [RW-1:0]                 rnd_q;
  logic [RW-SAMPLE_BITS:0]       top_bits;
  logic                          in_range;
  logic [SAMPLE_BITS-1:0]        filt_d;
  logic [SAMPLE_BITS-1:0]        filt_q;
  logic                          sat_q;

  assign rsum     = acc_q + HALF;
  assign top_bits = rnd_q[RW-1:SAMPLE_BITS-1];
  assign in_range = (&top_bits) | ~(|top_bits);

  always_comb begin
    if (in_range) begin
      filt_d = rnd_q[SAMPLE_BITS-1:0];
    end else if (rnd_q[RW-1]) begin
      filt_d = OUT_MIN;
    end else begin
      filt_d = OUT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= coef_i * hist_i;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctrl_i.rnd) begin
      rnd_q <= rsum[ACC_W-1:FRAC_BITS];
    end
    if (ctrl_i.load) begin
      filt_q <= filt_d;
      sat_q  <= ~in_range;
    end
  end

  assign filtered_o  = filt_q;
  assign saturated_o = sat_q;

endmodule

// ----- rtl/core/fir_seq.sv -----
// ----------------------------------------------------------------------------
// fir_seq: request sequencer of the FIR filter
// Clears both stores after reset, decodes requests, walks the taps through
// the shared datapath, writes the history ring and owns the output valid.
// ----------------------------------------------------------------------------
module fir_seq #(
  parameter int unsigned MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [fir_pkg::TAP_CNT_W-1:0]     tap_count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fir_pkg::CMD_W-1:0]         cmd_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  logic [fir_pkg::COEF_IDX_W-1:0]    coef_index_i,
  input  logic [fir_pkg::COEF_BITS-1:0]     coef_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              coef_we_o,
  output logic [$clog2(MAX_TAPS)-1:0]       coef_waddr_o,
  output logic [fir_pkg::COEF_BITS-1:0]     coef_wdata_o,
  output logic [$clog2(MAX_TAPS)-1:0]       coef_raddr_o,
  output logic                              hist_we_o,
  output logic [$clog2(MAX_TAPS)-1:0]       hist_waddr_o,
  output logic [SAMPLE_BITS-1:0]            hist_wdata_o,
  output logic [$clog2(MAX_TAPS)-1:0]       hist_raddr_o,
  output fir_pkg::mac_ctrl_t                ctrl_o
);
  import fir_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned CNT_W = $clog2(MAX_TAPS + 1);

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [AW-1:0]          ptr_inc;
  logic [CNT_W-1:0]       tap_q, tap_d;
  logic [CNT_W-1:0]       taps_q, taps_d;
  logic [CNT_W-1:0]       taps_use;
  logic [AW-1:0]          wp_q, wp_d;
  logic [AW:0]            start_sum;
  logic [AW-1:0]          start_pos;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                   v1_q, v1_d;
  logic                   v2_q;
  logic                   out_valid_q, out_valid_d;
  logic                   accept;
  logic                   coef_idx_ok;

  assign accept      = in_valid_i & in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign ptr_inc     = (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;
  assign coef_idx_ok = (32'(coef_index_i) < MAX_TAPS);

  always_comb begin
    if (tap_count_i == '0) begin
      taps_use = CNT_W'(1);
    end else if (32'(tap_count_i) > MAX_TAPS) begin
      taps_use = CNT_W'(MAX_TAPS);
    end else begin
      taps_use = CNT_W'(tap_count_i);
    end
  end

  // The oldest tap in use sits tap-count entries behind the write position.
  assign start_sum = (AW+1)'(wp_q) + (AW+1)'(MAX_TAPS) - (AW+1)'(taps_use);
  assign start_pos = (start_sum >= (AW+1)'(MAX_TAPS)) ?
                     AW'(start_sum - (AW+1)'(MAX_TAPS)) : AW'(start_sum);

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    tap_d        = tap_q;
    taps_d       = taps_q;
    wp_d         = wp_q;
    sample_d     = sample_q;
    v1_d         = 1'b0;
    out_valid_d  = out_valid_q & ~out_ready_i;
    coef_we_o    = 1'b0;
    coef_waddr_o = AW'(coef_index_i);
    coef_wdata_o = coef_value_i;
    hist_we_o    = 1'b0;
    hist_waddr_o = ptr_q;
    hist_wdata_o = '0;
    ctrl_o       = '0;
    ctrl_o.mul   = v1_q;
    ctrl_o.acc   = v2_q;

    unique case (state_q)
      S_INIT: begin
        coef_we_o    = 1'b1;
        coef_waddr_o = ptr_q;
        coef_wdata_o = '0;
        hist_we_o    = 1'b1;
        ptr_d        = ptr_inc;
        if (ptr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_SAMPLE: begin
              sample_d   = sample_i;
              taps_d     = taps_use;
              tap_d      = '0;
              ptr_d      = start_pos;
              ctrl_o.clr = 1'b1;
              state_d    = S_MAC;
            end
            CMD_LOAD: begin
              coef_we_o = coef_idx_ok;
            end
            CMD_CLEAR: begin
              ptr_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR: begin
        hist_we_o = 1'b1;
        ptr_d     = ptr_inc;
        if (ptr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_MAC: begin
        v1_d  = 1'b1;
        ptr_d = ptr_inc;
        tap_d = tap_q + 1'b1;
        if (tap_q == taps_q - 1'b1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_q) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        ctrl_o.rnd = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load  = 1'b1;
          hist_we_o    = 1'b1;
          hist_waddr_o = wp_q;
          hist_wdata_o = sample_q;
          wp_d         = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign coef_raddr_o = tap_q[AW-1:0];
  assign hist_raddr_o = ptr_q;
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      tap_q       <= '0;
      taps_q      <= '0;
      wp_q        <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      tap_q       <= tap_d;
      taps_q      <= taps_d;
      wp_q        <= wp_d;
      v1_q        <= v1_d;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

endmodule

// ----- rtl/core/fir_filter.sv -----
// ----------------------------------------------------------------------------
// fir_filter: direct-form FIR filter with one shared multiply-accumulate
// Q1.15 samples and coefficients, ring-buffer history, rounded and
// saturated output with a saturation flag.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (in_valid_i/in_ready_o) carries a command with its
// sample, coefficient index and coefficient value. A sample request returns
// one result on the output channel (out_valid_o/out_ready_i); the result is
// built from the samples before it, so the output lags the input by one.
// Neither a coefficient load nor a history clear returns a result. A
// sample request runs one tap per cycle through the single multiplier,
// then drains the pipeline, rounds the sum and loads the output register;
// the sequencer then returns to idle, where the next request is taken.
// The APB port holds the tap count at address 0.
// After reset the block sweeps both stores to zero and holds in_ready_o
// low meanwhile. The result stays in an output register until taken; a
// stalled receiver holds the next sample request at its final step and
// then blocks all requests; loads and clears ahead of it are still taken.
// ----------------------------------------------------------------------------
module fir_filter #(
  parameter int unsigned MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fir_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fir_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fir_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [fir_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  logic [fir_pkg::COEF_IDX_W-1:0]     coef_index_i,
  input  logic signed [fir_pkg::COEF_BITS-1:0] coef_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      filtered_o,
  output logic                               saturated_o
);
  import fir_pkg::*;

  localparam int unsigned AW = $clog2(MAX_TAPS);

  logic [TAP_CNT_W-1:0]   tap_count_q;
  logic [0:0]             reg_idx;
  logic                   cfg_write;
  logic                   coef_we;
  logic [AW-1:0]          coef_waddr;
  logic [COEF_BITS-1:0]   coef_wdata;
  logic [AW-1:0]          coef_raddr;
  logic [COEF_BITS-1:0]   coef_rdata;
  logic                   hist_we;
  logic [AW-1:0]          hist_waddr;
  logic [SAMPLE_BITS-1:0] hist_wdata;
  logic [AW-1:0]          hist_raddr;
  logic [SAMPLE_BITS-1:0] hist_rdata;
  mac_ctrl_t              mac_ctrl;

  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign prdata    = (reg_idx == REG_TAP_COUNT) ? APB_DATA_W'(tap_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RESET;
    end else if (cfg_write && (reg_idx == REG_TAP_COUNT)) begin
      tap_count_q <= pwdata[TAP_CNT_W-1:0];
    end
  end

  fir_seq #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tap_count_i  (tap_count_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .sample_i     (sample_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coef_we_o    (coef_we),
    .coef_waddr_o (coef_waddr),
    .coef_wdata_o (coef_wdata),
    .coef_raddr_o (coef_raddr),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_wdata_o (hist_wdata),
    .hist_raddr_o (hist_raddr),
    .ctrl_o       (mac_ctrl)
  );

  fir_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  fir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  fir_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .ctrl_i      (mac_ctrl),
    .coef_i      (coef_rdata),
    .hist_i      (hist_rdata),
    .filtered_o  (filtered_o),
    .saturated_o (saturated_o)
  );

endmodule

// ----- rtl/core/fir_chk.sv -----
// ----------------------------------------------------------------------------
// fir_chk: port-level checker of the FIR filter
// Watches the request, result and APB ports and is bound to the top level.
// ----------------------------------------------------------------------------
module fir_chk #(
  parameter int unsigned SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           pready,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [fir_pkg::CMD_W-1:0]      cmd_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [SAMPLE_BITS-1:0]         filtered_o,
  input logic                           saturated_o
);
  import fir_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o)
      && $stable(saturated_o))
    else $error("Result changed or vanished while stalled.");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_SAMPLE || cmd_i == CMD_CLEAR)
      |=> !in_ready_o)
    else $error("Ready stayed high after a sample or clear request.");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> filtered_o == OUT_MAX || filtered_o == OUT_MIN)
    else $error("Saturation flag set with an output inside the range.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("Register port stalled.");

endmodule

bind fir_filter fir_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fir_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .filtered_o  (filtered_o),
  .saturated_o (saturated_o)
);
